// ===== sv/trbe_pkg.sv =====
package trbe_pkg;

  localparam int unsigned RegionsDefault = 16;
  localparam int unsigned HoldResetMs    = 500;
  localparam int unsigned QueueDepth     = 2;

  localparam logic        CMD_REPORT  = 1'b0;
  localparam logic        CMD_PROGRAM = 1'b1;

  localparam logic [7:0]  CODE_DOWN_A = 8'h01;
  localparam logic [7:0]  CODE_DOWN_B = 8'h02;

  localparam logic [1:0]  KIND_PRESS   = 2'd0;
  localparam logic [1:0]  KIND_HOLD    = 2'd1;
  localparam logic [1:0]  KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  region_index;
    logic [15:0] region_x0;
    logic [15:0] region_y0;
    logic [15:0] region_x1;
    logic [15:0] region_y1;
    logic        region_enable;
    logic [7:0]  touch_count;
    logic [7:0]  event_code;
    logic [15:0] touch_x;
    logic [15:0] touch_y;
    logic [31:0] timestamp_ms;
  } item_t;

  typedef struct packed {
    logic [3:0]  hit_region;
    logic [1:0]  event_kind;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic [31:0] event_time;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [15:0] y1;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] x0;
  } bounds_t;

  // classified word handed from front to back
  typedef struct packed {
    logic        prog;
    logic        down;
    item_t       item;
  } qword_t;

endpackage

// ===== sv/trbe_front.sv =====
module trbe_front #(
  parameter int unsigned REGIONS = trbe_pkg::RegionsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  trbe_pkg::item_t item_i,
  output logic            busy_o,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output trbe_pkg::qword_t q_word_o
);

  localparam int unsigned Depth = trbe_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  trbe_pkg::qword_t q_mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic             is_prog, keep, push, pop;
  trbe_pkg::qword_t word;

  assign is_prog = (item_i.cmd == trbe_pkg::CMD_PROGRAM);
  assign keep    = is_prog ? (32'(item_i.region_index) < REGIONS)
                           : (item_i.touch_count != 8'd0);

  always_comb begin
    word      = '0;
    word.prog = is_prog;
    word.down = (item_i.event_code == trbe_pkg::CODE_DOWN_A) ||
                (item_i.event_code == trbe_pkg::CODE_DOWN_B);
    word.item = item_i;
  end

  assign busy_o    = (cnt_q == CntW'(Depth));
  assign push      = start_i && !busy_o && keep;
  assign q_valid_o = (cnt_q != '0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_word_o  = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= word;
    end
  end

endmodule

// ===== sv/trbe_back.sv =====
module trbe_back #(
  parameter int unsigned REGIONS = trbe_pkg::RegionsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  trbe_pkg::qword_t  q_word_i,
  input  logic [31:0]       hold_ms_i,
  output logic              result_strobe_o,
  output trbe_pkg::result_t result_o
);

  localparam int unsigned IdxW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_TAIL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  trbe_pkg::bounds_t bounds_mem [REGIONS];
  logic [31:0]       start_mem  [REGIONS];
  trbe_pkg::bounds_t bounds_rd_q;
  logic [31:0]       start_rd_q;

  logic [REGIONS-1:0] on_q, on_d, pressed_q, pressed_d, holding_q, holding_d;

  logic        ev_v_q;
  logic [IdxW-1:0] ev_idx_q;

  logic        down_q;
  logic [15:0] x_q, y_q;
  logic [31:0] ts_q;

  trbe_pkg::result_t pend_q, pend_d, out_q, out_d;
  logic              pend_v_q, pend_v_d, strobe_q, strobe_d;

  logic            pop, prog_wr, start_wr;
  logic [IdxW-1:0] prog_idx;
  logic            in_rect, emit;
  logic [1:0]      kind;
  logic [31:0]     elapsed;

  assign q_ready_o = (state_q == S_IDLE);
  assign pop       = q_valid_i && q_ready_o;
  assign prog_wr   = pop && q_word_i.prog;
  assign prog_idx  = IdxW'(q_word_i.item.region_index);

  assign in_rect = (x_q >= bounds_rd_q.x0) && (x_q <= bounds_rd_q.x1) &&
                   (y_q >= bounds_rd_q.y0) && (y_q <= bounds_rd_q.y1);
  assign elapsed = ts_q - start_rd_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    on_d      = on_q;
    pressed_d = pressed_q;
    holding_d = holding_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    strobe_d  = 1'b0;
    emit      = 1'b0;
    kind      = trbe_pkg::KIND_PRESS;
    start_wr  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (prog_wr) begin
          on_d[prog_idx]      = q_word_i.item.region_enable;
          pressed_d[prog_idx] = 1'b0;
          holding_d[prog_idx] = 1'b0;
        end else if (pop) begin
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == IdxW'(REGIONS - 1)) begin
          state_d = S_TAIL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_TAIL: state_d = S_FLUSH;
      S_FLUSH: begin
        if (pend_v_q) begin
          out_d             = pend_q;
          out_d.last_of_run = 1'b1;
          strobe_d          = 1'b1;
        end
        pend_v_d = 1'b0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (ev_v_q && on_q[ev_idx_q]) begin
      if (down_q) begin
        if (in_rect) begin
          if (!pressed_q[ev_idx_q]) begin
            pressed_d[ev_idx_q] = 1'b1;
            start_wr            = 1'b1;
            emit                = 1'b1;
            kind                = trbe_pkg::KIND_PRESS;
          end else if (!holding_q[ev_idx_q] && (elapsed >= hold_ms_i)) begin
            holding_d[ev_idx_q] = 1'b1;
            emit                = 1'b1;
            kind                = trbe_pkg::KIND_HOLD;
          end
        end else begin
          pressed_d[ev_idx_q] = 1'b0;
          holding_d[ev_idx_q] = 1'b0;
        end
      end else if (pressed_q[ev_idx_q]) begin
        emit                = in_rect;
        kind                = trbe_pkg::KIND_RELEASE;
        pressed_d[ev_idx_q] = 1'b0;
        holding_d[ev_idx_q] = 1'b0;
      end
    end

    // hold each event back one step so the final one can carry the run marker
    if (emit) begin
      if (pend_v_q) begin
        out_d    = pend_q;
        strobe_d = 1'b1;
      end
      pend_d.hit_region  = 4'(ev_idx_q);
      pend_d.event_kind  = kind;
      pend_d.event_x     = x_q;
      pend_d.event_y     = y_q;
      pend_d.event_time  = ts_q;
      pend_d.last_of_run = 1'b0;
      pend_v_d           = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      on_q      <= '0;
      pressed_q <= '0;
      holding_q <= '0;
      ev_v_q    <= 1'b0;
      pend_v_q  <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      on_q      <= on_d;
      pressed_q <= pressed_d;
      holding_q <= holding_d;
      ev_v_q    <= (state_q == S_SCAN);
      pend_v_q  <= pend_v_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q <= cnt_q;
    pend_q   <= pend_d;
    out_q    <= out_d;
    if (pop && !q_word_i.prog) begin
      down_q <= q_word_i.down;
      x_q    <= q_word_i.item.touch_x;
      y_q    <= q_word_i.item.touch_y;
      ts_q   <= q_word_i.item.timestamp_ms;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prog_wr) begin
      bounds_mem[prog_idx] <= {q_word_i.item.region_y1, q_word_i.item.region_x1,
                               q_word_i.item.region_y0, q_word_i.item.region_x0};
    end
    bounds_rd_q <= bounds_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (start_wr) begin
      start_mem[ev_idx_q] <= ts_q;
    end
    start_rd_q <= start_mem[cnt_q];
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = out_q;

endmodule

// ===== sv/touch_region_button_events_core.sv =====
// Touch region button event core. Words are taken on start_i while busy_o is low into a
// two-word queue; empty reports and out-of-range program words are dropped there. A program
// word is applied without the back end leaving idle. A report walks the region table one
// entry per cycle through the registered bounds and start-time memories, so it occupies the back
// end through its scan, tail and flush states; busy_o rises only when both queue slots are full.
// Events come out on result_o at most one per cycle, each marked by a one-cycle
// result_strobe_o; there is no way to hold them off, so the receiver must take every strobe.
// The last event of a report has last_of_run set. hold_time_ms is written on the cfg
// channel, which is always ready, and must only change while the block is idle.
module touch_region_button_events_core #(
  parameter int unsigned REGIONS = trbe_pkg::RegionsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  trbe_pkg::item_t   item_i,
  output logic              busy_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i,
  output logic              result_strobe_o,
  output trbe_pkg::result_t result_o
);

  logic [31:0]      hold_ms_q;
  logic             q_valid, q_ready;
  trbe_pkg::qword_t q_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms_q <= 32'(trbe_pkg::HoldResetMs);
    end else if (cfg_valid_i && cfg_ready_o) begin
      hold_ms_q <= cfg_data_i;
    end
  end

  trbe_front #(
    .REGIONS(REGIONS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .q_valid_o(q_valid),
    .q_ready_i(q_ready),
    .q_word_o (q_word)
  );

  trbe_back #(
    .REGIONS(REGIONS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_word_i       (q_word),
    .hold_ms_i      (hold_ms_q),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

endmodule
